// ===== rtl/core/lrcc_pkg.sv =====
// shared types, constants and reset values for the learning remote channel controller
// no dependencies; imported by lrcc_regs, lrcc_ctrl, lrcc_dp and the top level
package lrcc_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 16;
  localparam int unsigned CODE_W          = 32;
  localparam int unsigned KEY_W           = 4;
  localparam int unsigned ID_W            = CODE_W - KEY_W;
  localparam int unsigned CHAN_W          = 4;
  localparam int unsigned CFG_W           = 16;
  localparam int unsigned APB_AW          = 5;
  localparam int unsigned APB_DW          = 32;

  localparam logic [CFG_W-1:0] CNT_SAT = '1;

  localparam logic [CFG_W-1:0] RST_LEARN_MIN      = 16'd1000;
  localparam logic [CFG_W-1:0] RST_LEARN_MAX      = 16'd3000;
  localparam logic [CFG_W-1:0] RST_ERASE_MIN      = 16'd5000;
  localparam logic [CFG_W-1:0] RST_ERASE_MAX      = 16'd15000;
  localparam logic [CFG_W-1:0] RST_REPEAT_TIMEOUT = 16'd500;
  localparam logic [CFG_W-1:0] RST_BLINK_NORMAL   = 16'd1000;
  localparam logic [CFG_W-1:0] RST_BLINK_LEARN    = 16'd100;
  localparam logic [CFG_W-1:0] RST_ERASE_HOLD     = 16'd3000;

  typedef enum logic [2:0] {
    REG_LEARN_MIN,
    REG_LEARN_MAX,
    REG_ERASE_MIN,
    REG_ERASE_MAX,
    REG_REPEAT_TIMEOUT,
    REG_BLINK_NORMAL,
    REG_BLINK_LEARN,
    REG_ERASE_HOLD
  } reg_idx_e;

  typedef enum logic [2:0] {
    EV_NONE,
    EV_ACTION,
    EV_UNKNOWN,
    EV_LEARNED,
    EV_KNOWN,
    EV_LEARN_ENTER,
    EV_ERASED
  } event_e;

  typedef struct packed {
    logic [CFG_W-1:0] learn_min;
    logic [CFG_W-1:0] learn_max;
    logic [CFG_W-1:0] erase_min;
    logic [CFG_W-1:0] erase_max;
    logic [CFG_W-1:0] repeat_timeout;
    logic [CFG_W-1:0] blink_normal;
    logic [CFG_W-1:0] blink_learn;
    logic [CFG_W-1:0] erase_hold;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic rd_en;
    logic compare;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_search;
    logic table_empty;
    logic match;
    logic last_idx;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/core/lrcc_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
module lrcc_ram #(
  parameter int unsigned WIDTH = 28,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/lrcc_regs.sv =====
// apb configuration register file, eight 16-bit registers at word addresses
// depends on lrcc_pkg
module lrcc_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lrcc_pkg::APB_AW-1:0] paddr,
  input  logic [lrcc_pkg::APB_DW-1:0] pwdata,
  output logic [lrcc_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output lrcc_pkg::cfg_t              cfg_o
);
  import lrcc_pkg::*;

  cfg_t             cfg_q;
  reg_idx_e         idx;
  logic             wr_en;
  logic [CFG_W-1:0] wval;
  logic [CFG_W-1:0] rval;

  assign idx    = reg_idx_e'(paddr[APB_AW-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign wval   = pwdata[CFG_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.learn_min      <= RST_LEARN_MIN;
      cfg_q.learn_max      <= RST_LEARN_MAX;
      cfg_q.erase_min      <= RST_ERASE_MIN;
      cfg_q.erase_max      <= RST_ERASE_MAX;
      cfg_q.repeat_timeout <= RST_REPEAT_TIMEOUT;
      cfg_q.blink_normal   <= RST_BLINK_NORMAL;
      cfg_q.blink_learn    <= RST_BLINK_LEARN;
      cfg_q.erase_hold     <= RST_ERASE_HOLD;
    end else if (wr_en) begin
      unique case (idx)
        REG_LEARN_MIN:      cfg_q.learn_min      <= wval;
        REG_LEARN_MAX:      cfg_q.learn_max      <= wval;
        REG_ERASE_MIN:      cfg_q.erase_min      <= wval;
        REG_ERASE_MAX:      cfg_q.erase_max      <= wval;
        REG_REPEAT_TIMEOUT: cfg_q.repeat_timeout <= wval;
        REG_BLINK_NORMAL:   cfg_q.blink_normal   <= wval;
        REG_BLINK_LEARN:    cfg_q.blink_learn    <= wval;
        REG_ERASE_HOLD:     cfg_q.erase_hold     <= wval;
        default:            cfg_q.erase_hold     <= cfg_q.erase_hold;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LEARN_MIN:      rval = cfg_q.learn_min;
      REG_LEARN_MAX:      rval = cfg_q.learn_max;
      REG_ERASE_MIN:      rval = cfg_q.erase_min;
      REG_ERASE_MAX:      rval = cfg_q.erase_max;
      REG_REPEAT_TIMEOUT: rval = cfg_q.repeat_timeout;
      REG_BLINK_NORMAL:   rval = cfg_q.blink_normal;
      REG_BLINK_LEARN:    rval = cfg_q.blink_learn;
      REG_ERASE_HOLD:     rval = cfg_q.erase_hold;
      default:            rval = '0;
    endcase
  end

  assign prdata = {{(APB_DW - CFG_W){1'b0}}, rval};
  assign cfg_o  = cfg_q;

endmodule

// ===== rtl/core/lrcc_ctrl.sv =====
// controller state machine: request capture, table search sequencing, result commit
// depends on lrcc_pkg
module lrcc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lrcc_pkg::sts_t      sts_i,
  output lrcc_pkg::cmd_t      cmd_o
);
  import lrcc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_READ,
    ST_COMPARE,
    ST_COMMIT
  } state_e;

  state_e state_q;
  state_e state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts_i.need_search && !sts_i.table_empty) begin
          state_d = ST_READ;
        end else begin
          state_d = ST_COMMIT;
        end
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_COMPARE;
      end
      ST_COMPARE: begin
        cmd_o.compare = 1'b1;
        if (sts_i.match || sts_i.last_idx) begin
          state_d = ST_COMMIT;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_COMMIT: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

// ===== rtl/core/lrcc_dp.sv =====
// datapath: tick state, learned id table, tick update logic and result register
// depends on lrcc_pkg and lrcc_ram
module lrcc_dp #(
  parameter int unsigned TABLE_DEPTH = lrcc_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lrcc_pkg::cfg_t              cfg_i,
  input  lrcc_pkg::cmd_t              cmd_i,
  output lrcc_pkg::sts_t              sts_o,
  input  logic                        code_valid_i,
  input  logic [lrcc_pkg::CODE_W-1:0] code_i,
  input  logic                        key_down_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [lrcc_pkg::CHAN_W-1:0] channels_o,
  output logic                        led_o,
  output logic                        mode_o,
  output logic                        busy_res_o,
  output logic [2:0]                  event_res_o
);
  import lrcc_pkg::*;

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

  // latched request
  logic              cv_q;
  logic [CODE_W-1:0] code_q;
  logic              kd_q;

  // search
  logic [IDX_W-1:0] idx_q;
  logic             found_q;
  logic [ID_W-1:0]  rd_id;

  // tick state
  logic [CHAN_W-1:0] chan_q, chan_d;
  logic              led_q, led_d;
  logic              lm_q, lm_d;
  logic [CODE_W-1:0] last_q, last_d;
  logic [CFG_W-1:0]  quiet_q, quiet_d;
  logic [CFG_W-1:0]  press_q, press_d;
  logic [CFG_W-1:0]  blink_q, blink_d;
  logic              first_q, first_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CFG_W-1:0]  hold_q, hold_d;
  event_e            ev_q, ev_d;
  logic              out_valid_q;

  logic              tbl_we;
  logic              do_blink;
  logic [CFG_W-1:0]  period;

  lrcc_ram #(
    .WIDTH (ID_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (code_q[CODE_W-1:KEY_W]),
    .re_i    (cmd_i.rd_en),
    .raddr_i (idx_q),
    .rdata_o (rd_id)
  );

  assign sts_o.need_search = (hold_q == '0) && cv_q && (code_q != last_q);
  assign sts_o.table_empty = (count_q == '0);
  assign sts_o.match       = (rd_id == code_q[CODE_W-1:KEY_W]);
  assign sts_o.last_idx    = ((CNT_W'(idx_q) + 1'b1) >= count_q);
  assign sts_o.out_free    = !out_valid_q || !out_stall_i;

  // request latch and search index
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cv_q   <= code_valid_i;
      code_q <= code_i;
      kd_q   <= key_down_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      found_q <= 1'b0;
    end else if (cmd_i.capture) begin
      idx_q   <= '0;
      found_q <= 1'b0;
    end else if (cmd_i.compare) begin
      if (sts_o.match) begin
        found_q <= 1'b1;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  // one tick of the controller, applied at commit
  always_comb begin
    chan_d   = chan_q;
    led_d    = led_q;
    lm_d     = lm_q;
    last_d   = last_q;
    quiet_d  = quiet_q;
    press_d  = press_q;
    blink_d  = blink_q;
    first_d  = first_q;
    count_d  = count_q;
    hold_d   = hold_q;
    ev_d     = EV_NONE;
    tbl_we   = 1'b0;
    do_blink = 1'b1;

    if (hold_q != '0) begin
      // erase hold: inputs ignored, led released on the last tick
      hold_d = hold_q - 1'b1;
      if (hold_d == '0) begin
        led_d = ~led_q;
      end else begin
        do_blink = 1'b0;
      end
    end else begin
      if (cv_q) begin
        quiet_d = '0;
        if (code_q != last_q) begin
          last_d = code_q;
          if (!lm_q) begin
            if (found_q) begin
              chan_d = chan_q ^ code_q[KEY_W-1:0];
              ev_d   = EV_ACTION;
            end else begin
              ev_d = EV_UNKNOWN;
            end
          end else begin
            if (found_q) begin
              ev_d = EV_KNOWN;
            end else if (count_q < CNT_FULL) begin
              tbl_we  = cmd_i.commit;
              count_d = count_q + 1'b1;
              ev_d    = EV_LEARNED;
            end else begin
              ev_d = EV_UNKNOWN;
            end
            lm_d = 1'b0;
          end
        end
      end else begin
        if (quiet_q >= cfg_i.repeat_timeout) begin
          last_d = '0;
        end
        if (quiet_q != CNT_SAT) begin
          quiet_d = quiet_q + 1'b1;
        end
      end

      if (kd_q) begin
        if (press_q != CNT_SAT) begin
          press_d = press_q + 1'b1;
        end
      end else begin
        if ((press_q > cfg_i.learn_min) && (press_q < cfg_i.learn_max)) begin
          lm_d = 1'b1;
          ev_d = EV_LEARN_ENTER;
        end else if ((press_q > cfg_i.erase_min) && (press_q < cfg_i.erase_max)) begin
          count_d = '0;
          ev_d    = EV_ERASED;
          hold_d  = cfg_i.erase_hold;
          if (cfg_i.erase_hold == '0) begin
            led_d = 1'b0;
          end else begin
            led_d    = 1'b1;
            do_blink = 1'b0;
          end
        end
        press_d = '0;
      end
    end

    period = lm_d ? cfg_i.blink_learn : cfg_i.blink_normal;
    if (do_blink) begin
      if (first_q || (blink_q >= period)) begin
        led_d   = ~led_d;
        blink_d = '0;
        first_d = 1'b0;
      end else begin
        blink_d = blink_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q      <= '0;
      led_q       <= 1'b0;
      lm_q        <= 1'b0;
      last_q      <= '0;
      quiet_q     <= '0;
      press_q     <= '0;
      blink_q     <= '0;
      first_q     <= 1'b1;
      count_q     <= '0;
      hold_q      <= '0;
      ev_q        <= EV_NONE;
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      chan_q      <= chan_d;
      led_q       <= led_d;
      lm_q        <= lm_d;
      last_q      <= last_d;
      quiet_q     <= quiet_d;
      press_q     <= press_d;
      blink_q     <= blink_d;
      first_q     <= first_d;
      count_q     <= count_d;
      hold_q      <= hold_d;
      ev_q        <= ev_d;
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign channels_o  = chan_q;
  assign led_o       = led_q;
  assign mode_o      = lm_q;
  assign busy_res_o  = (hold_q != '0);
  assign event_res_o = ev_q;

endmodule

// ===== rtl/core/learning_remote_channel_controller.sv =====
// top level of the learning remote channel controller
// depends on lrcc_pkg, lrcc_regs, lrcc_ctrl, lrcc_dp (which holds lrcc_ram)
//
//  channel | handshake                 | payload
//  --------+---------------------------+-----------------------------------------------
//  in      | in_valid_i / in_stall_o   | code_valid_i, code_i[31:0], key_down_i
//  out     | out_valid_o / out_stall_i | channels_o[3:0], led_o, mode_o, busy_res_o,
//          |                           | event_res_o[2:0]
//  config  | apb psel/penable/pready   | paddr[4:2] register index, pwdata[15:0]
//
// each request is one millisecond tick; it passes through capture, decide and commit,
// with a read and a compare for every learned id examined when a new code has to be
// looked up; the ids are read one at a time through the single read port of the id table
// asynchronous active-low reset clears all state but the latched request; table contents
// are not cleared, only the fill count, so no clearing pass is needed
// a new request is taken while the previous result still waits on out_stall_i;
// it is held at commit until that result has been taken
module learning_remote_channel_controller #(
  parameter int unsigned TABLE_DEPTH = lrcc_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        code_valid_i,
  input  logic [lrcc_pkg::CODE_W-1:0] code_i,
  input  logic                        key_down_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [lrcc_pkg::CHAN_W-1:0] channels_o,
  output logic                        led_o,
  output logic                        mode_o,
  output logic                        busy_res_o,
  output logic [2:0]                  event_res_o,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lrcc_pkg::APB_AW-1:0] paddr,
  input  logic [lrcc_pkg::APB_DW-1:0] pwdata,
  output logic [lrcc_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import lrcc_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  // register file; to be written only while no request is in flight, which the block does not enforce
  lrcc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer: capture, walk the id table, commit when the result slot is free
  lrcc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // tick state, id table and result register
  lrcc_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .code_valid_i (code_valid_i),
    .code_i       (code_i),
    .key_down_i   (key_down_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .channels_o   (channels_o),
    .led_o        (led_o),
    .mode_o       (mode_o),
    .busy_res_o   (busy_res_o),
    .event_res_o  (event_res_o)
  );

endmodule
